### design/dnd_pkg.sv
// dnd_pkg: shared constants, field widths and command type of the DNS name decompressor.
// No dependencies; every other design file imports it.
package dnd_pkg;

    // Sizing
    localparam int PACKET_BYTES   = 4096;
    localparam int MAX_NAME_BYTES = 255;
    localparam int MAX_JUMPS      = 50;

    // Transaction field widths
    localparam int IDX_W   = 12;
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 13;
    localparam int OFF_W   = 12;
    localparam int CHUNK_W = 64;
    localparam int CNT_W   = 4;
    localparam int CONS_W  = 9;

    // Derived widths
    localparam int PTR_W    = 14;
    localparam int STORE_AW = $clog2(PACKET_BYTES);
    localparam int POS_W    = ((STORE_AW > PTR_W) ? STORE_AW : PTR_W) + 1;
    localparam int COPY_W   = $clog2(MAX_NAME_BYTES + 1);
    localparam int JUMP_W   = $clog2(MAX_JUMPS + 2);
    localparam int LANES    = CHUNK_W / BYTE_W;
    localparam int LANE_W   = $clog2(LANES);

    // Command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Wire-format byte codes
    localparam logic [BYTE_W-1:0] PTR_MARK    = 8'hC0;
    localparam logic [BYTE_W-1:0] PTR_HI_MASK = 8'h3F;
    localparam logic [BYTE_W-1:0] NAME_END    = 8'h00;

    typedef enum logic
    {
        REQ_LOAD    = 1'b0,
        REQ_RESOLVE = 1'b1
    } req_kind_t;

    typedef struct packed
    {
        req_kind_t          kind;
        logic [IDX_W-1:0]   index;
        logic [BYTE_W-1:0]  value;
        logic [POS_W-1:0]   len;    // already clipped to the store size
        logic [OFF_W-1:0]   start;
    } cmd_t;

endpackage

### design/dnd_if.sv
// dnd_req_if / dnd_res_if: valid/ready channels of the DNS name decompressor.
// Depends on dnd_pkg for field widths.
interface dnd_req_if;
    import dnd_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [IDX_W-1:0]  byte_index;
    logic [BYTE_W-1:0] byte_value;
    logic [LEN_W-1:0]  packet_length;
    logic [OFF_W-1:0]  start_offset;

    modport source (output valid, req_type, byte_index, byte_value, packet_length,
                    start_offset, input ready);
    modport sink   (input valid, req_type, byte_index, byte_value, packet_length,
                    start_offset, output ready);
endinterface

interface dnd_res_if;
    import dnd_pkg::*;

    logic               valid;
    logic               ready;
    logic [CHUNK_W-1:0] name_chunk;
    logic [CNT_W-1:0]   chunk_bytes;
    logic               is_last;
    logic               error_flag;
    logic [CONS_W-1:0]  consumed_length;

    modport source (output valid, name_chunk, chunk_bytes, is_last, error_flag,
                    consumed_length, input ready);
    modport sink   (input valid, name_chunk, chunk_bytes, is_last, error_flag,
                    consumed_length, output ready);
endinterface

### design/dns_name_decompressor.sv
// dns_name_decompressor: top level of the DNS name pointer decoder.
// Depends on dnd_pkg, dnd_if, dnd_front, dnd_queue and dnd_back.
//
// Usage
//   req (sink): each transaction is either a load (req_type 0) that writes
//     byte_value at byte_index of the packet store, or a resolve (req_type 1)
//     that walks the wire-form name at start_offset of a packet of
//     packet_length bytes. Lengths above the store size are clipped.
//   res (source): a resolve yields one transaction per eight copied name
//     bytes, then a final one with is_last set, the leftover bytes, the
//     error flag and the consumed length. Loads yield nothing.
// Back end steps
//   Requests pass a 4-entry command queue, which registers each command
//   before the back end takes it. A load is written to the store from the
//   idle state. A resolve runs a start step, a walk step for each copied
//   byte, a walk and a pointer step for each pointer followed, then the
//   closing step and finish. The walk is paced by the single read port of
//   the packet store, read once per walk step.
// Reset
//   rst_n clears the queue, the walker and the result register. The packet
//   store is not cleared; only loaded bytes may be resolved.
// Stall
//   A full result register held by res.ready stalls the walker on the next
//   chunk; requests keep queueing until the queue fills, then req.ready drops.
module dns_name_decompressor
(
    input  logic        clk,
    input  logic        rst_n,
    dnd_req_if.sink     req,
    dnd_res_if.source   res
);
    import dnd_pkg::*;

    cmd_t push_cmd;
    cmd_t pop_cmd;
    logic push_valid;
    logic queue_full;
    logic queue_empty;
    logic pop;

    // front: accept and classify request transactions
    dnd_front u_front
    (
        .req        (req),
        .push_cmd   (push_cmd),
        .push_valid (push_valid),
        .queue_full (queue_full)
    );

    // decouples acceptance from the walk
    dnd_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cmd   (push_cmd),
        .push_valid (push_valid),
        .full       (queue_full),
        .pop_cmd    (pop_cmd),
        .empty      (queue_empty),
        .pop        (pop)
    );

    // back: store writes, name walk, result transactions
    dnd_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (pop_cmd),
        .queue_empty (queue_empty),
        .pop         (pop),
        .res         (res)
    );

endmodule

### design/dnd_front.sv
// dnd_front: accepts request transactions, classifies them and builds queue commands.
// Depends on dnd_pkg and dnd_req_if.
module dnd_front
(
    dnd_req_if.sink         req,
    output dnd_pkg::cmd_t   push_cmd,
    output logic            push_valid,
    input  logic            queue_full
);
    import dnd_pkg::*;

    logic [POS_W-1:0] len_wide;
    logic [POS_W-1:0] idx_wide;
    logic             drop;

    assign len_wide = POS_W'(req.packet_length);
    assign idx_wide = POS_W'(req.byte_index);

    // loads beyond the store are swallowed here
    assign drop = (req.req_type == REQ_LOAD) && (idx_wide >= POS_W'(PACKET_BYTES));

    assign req.ready = !queue_full;
    assign push_valid = req.valid && !queue_full && !drop;

    always_comb
    begin
        push_cmd.kind  = req_kind_t'(req.req_type);
        push_cmd.index = req.byte_index;
        push_cmd.value = req.byte_value;
        push_cmd.start = req.start_offset;
        if (len_wide > POS_W'(PACKET_BYTES))
        begin
            push_cmd.len = POS_W'(PACKET_BYTES);
        end
        else
        begin
            push_cmd.len = len_wide;
        end
    end

endmodule

### design/dnd_queue.sv
// dnd_queue: short command FIFO between the front and the back end.
// Depends on dnd_pkg.
module dnd_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  dnd_pkg::cmd_t   push_cmd,
    input  logic            push_valid,
    output logic            full,
    output dnd_pkg::cmd_t   pop_cmd,
    output logic            empty,
    input  logic            pop
);
    import dnd_pkg::*;

    cmd_t                entries [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg;
    logic [QUEUE_AW:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push_valid && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_cmd;
        end
    end

    // occupancy never runs past the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue occupancy overflow");

endmodule

### design/dnd_back.sv
// dnd_back: packet store, name walker and result register.
// Depends on dnd_pkg and dnd_res_if.
module dnd_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  dnd_pkg::cmd_t   cmd,
    input  logic            queue_empty,
    output logic            pop,
    dnd_res_if.source       res
);
    import dnd_pkg::*;

    typedef enum logic [3:0]
    {
        ST_IDLE   = 4'b0001,
        ST_WALK   = 4'b0010,
        ST_PTR    = 4'b0100,
        ST_FINISH = 4'b1000
    } walk_state_t;

    localparam logic [LANE_W-1:0] LANE_LAST = LANE_W'(LANES - 1);

    walk_state_t          state_reg, state_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [POS_W-1:0]     len_reg, len_next;
    logic [STORE_AW-1:0]  addr_reg, addr_next;
    logic [5:0]           hi_reg, hi_next;
    logic [COPY_W-1:0]    copied_reg, copied_next;
    logic [JUMP_W-1:0]    jumps_reg, jumps_next;
    logic [CONS_W-1:0]    consumed_reg, consumed_next;
    logic                 jumped_reg, jumped_next;
    logic                 landed_reg, landed_next;
    logic                 err_reg, err_next;
    logic [CHUNK_W-1:0]   chunk_reg, chunk_next;
    logic [LANE_W-1:0]    pend_reg, pend_next;

    logic                 out_valid_reg;
    logic [CHUNK_W-1:0]   out_chunk_reg;
    logic [CNT_W-1:0]     out_bytes_reg;
    logic                 out_last_reg;
    logic                 out_err_reg;
    logic [CONS_W-1:0]    out_cons_reg;

    logic [BYTE_W-1:0]    store [PACKET_BYTES];
    logic [BYTE_W-1:0]    rd_data_reg;
    logic [STORE_AW-1:0]  rd_addr;
    logic                 wr_en;
    logic [STORE_AW-1:0]  wr_addr;

    logic                 out_free;
    logic                 emit;
    logic [CHUNK_W-1:0]   emit_chunk;
    logic [CNT_W-1:0]     emit_bytes;
    logic                 emit_last;
    logic                 emit_err;
    logic [CONS_W-1:0]    emit_cons;

    logic [POS_W-1:0]     pos_inc;
    logic [POS_W-1:0]     start_wide;
    logic [POS_W-1:0]     index_wide;
    logic [POS_W-1:0]     target;
    logic [CHUNK_W-1:0]   chunk_fill;
    logic                 is_ptr;

    assign out_free   = !out_valid_reg || res.ready;
    assign pos_inc    = pos_reg + 1'b1;
    assign start_wide = POS_W'(cmd.start);
    assign index_wide = POS_W'(cmd.index);
    assign target     = POS_W'({hi_reg, rd_data_reg});
    assign is_ptr     = (rd_data_reg & PTR_MARK) == PTR_MARK;
    assign wr_addr    = index_wide[STORE_AW-1:0];

    always_comb
    begin
        chunk_fill = chunk_reg;
        chunk_fill[pend_reg*BYTE_W +: BYTE_W] = rd_data_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        hi_next       = hi_reg;
        copied_next   = copied_reg;
        jumps_next    = jumps_reg;
        consumed_next = consumed_reg;
        jumped_next   = jumped_reg;
        landed_next   = landed_reg;
        err_next      = err_reg;
        chunk_next    = chunk_reg;
        pend_next     = pend_reg;
        rd_addr       = addr_reg;
        pop           = 1'b0;
        wr_en         = 1'b0;
        emit          = 1'b0;
        emit_chunk    = chunk_reg;
        emit_bytes    = CNT_W'(LANES);
        emit_last     = 1'b0;
        emit_err      = 1'b0;
        emit_cons     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop = 1'b1;
                    if (cmd.kind == REQ_LOAD)
                    begin
                        wr_en = 1'b1;
                    end
                    else
                    begin
                        len_next      = cmd.len;
                        pos_next      = start_wide;
                        copied_next   = '0;
                        jumps_next    = '0;
                        consumed_next = '0;
                        jumped_next   = 1'b0;
                        landed_next   = 1'b0;
                        chunk_next    = '0;
                        pend_next     = '0;
                        if (start_wide >= cmd.len)
                        begin
                            err_next   = 1'b1;
                            state_next = ST_FINISH;
                        end
                        else
                        begin
                            err_next   = 1'b0;
                            rd_addr    = start_wide[STORE_AW-1:0];
                            state_next = ST_WALK;
                        end
                    end
                end
            end

            ST_WALK:
            begin
                if (rd_data_reg == NAME_END)
                begin
                    // a pointer landing on the terminator is malformed
                    err_next   = landed_reg;
                    state_next = ST_FINISH;
                end
                else if (copied_reg >= COPY_W'(MAX_NAME_BYTES) ||
                         jumps_reg > JUMP_W'(MAX_JUMPS))
                begin
                    err_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else if (is_ptr)
                begin
                    landed_next = 1'b0;
                    if (pos_inc >= len_reg)
                    begin
                        err_next   = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        hi_next    = rd_data_reg[5:0] & PTR_HI_MASK[5:0];
                        rd_addr    = pos_inc[STORE_AW-1:0];
                        state_next = ST_PTR;
                    end
                end
                else if (pend_reg != LANE_LAST || out_free)
                begin
                    // copy one raw byte; hold while a full chunk cannot leave
                    landed_next = 1'b0;
                    if (pend_reg == LANE_LAST)
                    begin
                        emit       = 1'b1;
                        emit_chunk = chunk_fill;
                        chunk_next = '0;
                        pend_next  = '0;
                    end
                    else
                    begin
                        chunk_next = chunk_fill;
                        pend_next  = pend_reg + 1'b1;
                    end
                    if (!jumped_reg)
                    begin
                        consumed_next = consumed_reg + 1'b1;
                    end
                    copied_next = copied_reg + 1'b1;
                    pos_next    = pos_inc;
                    if (pos_inc >= len_reg)
                    begin
                        err_next   = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        rd_addr = pos_inc[STORE_AW-1:0];
                    end
                end
            end

            ST_PTR:
            begin
                if (target >= len_reg)
                begin
                    err_next   = 1'b1;
                    state_next = ST_FINISH;
                end
                else
                begin
                    if (!jumped_reg)
                    begin
                        consumed_next = consumed_reg + CONS_W'(2);
                        jumped_next   = 1'b1;
                    end
                    pos_next    = target;
                    rd_addr     = target[STORE_AW-1:0];
                    landed_next = 1'b1;
                    jumps_next  = jumps_reg + 1'b1;
                    state_next  = ST_WALK;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_chunk = chunk_reg;
                    emit_bytes = CNT_W'(pend_reg);
                    emit_last  = 1'b1;
                    emit_err   = err_reg;
                    if (err_reg)
                    begin
                        emit_cons = '0;
                    end
                    else if (jumped_reg)
                    begin
                        emit_cons = consumed_reg;
                    end
                    else
                    begin
                        emit_cons = consumed_reg + 1'b1;
                    end
                    chunk_next = '0;
                    pend_next  = '0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        addr_next = rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        len_reg      <= len_next;
        addr_reg     <= addr_next;
        hi_reg       <= hi_next;
        copied_reg   <= copied_next;
        jumps_reg    <= jumps_next;
        consumed_reg <= consumed_next;
        jumped_reg   <= jumped_next;
        landed_reg   <= landed_next;
        err_reg      <= err_next;
        chunk_reg    <= chunk_next;
        if (emit)
        begin
            out_chunk_reg <= emit_chunk;
            out_bytes_reg <= emit_bytes;
            out_last_reg  <= emit_last;
            out_err_reg   <= emit_err;
            out_cons_reg  <= emit_cons;
        end
    end

    // packet store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store[wr_addr] <= cmd.value;
        end
        rd_data_reg <= store[rd_addr];
    end

    assign res.valid           = out_valid_reg;
    assign res.name_chunk      = out_chunk_reg;
    assign res.chunk_bytes     = out_bytes_reg;
    assign res.is_last         = out_last_reg;
    assign res.error_flag      = out_err_reg;
    assign res.consumed_length = out_cons_reg;

    // no partial chunk is left behind between resolves
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (pend_reg == '0))
        else $error("chunk bytes left over in idle");

    // before the first jump every copied byte counts toward the consumed length
    a_consumed_track: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && !jumped_reg) |-> (consumed_reg == CONS_W'(copied_reg)))
        else $error("consumed length out of step with copied bytes");

    // the result register is never overwritten while still held
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && out_valid_reg) |-> res.ready)
        else $error("result register overwritten");

    // pointer low byte is only fetched right after a pointer byte
    a_ptr_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PTR) |-> ($past(state_reg) == ST_WALK))
        else $error("pointer state entered out of walk");

endmodule

### bench/testbench.sv
// testbench: self-checking bench for dns_name_decompressor (loads, name walks, all error exits).
// Depends on dnd_pkg and the dnd_req_if / dnd_res_if channel interfaces from the design.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dnd_pkg::*;

    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 11;
    localparam int LONG_HOLD     = 1500;   // receiver hold-off that backs up the whole block
    localparam int STALL_LIMIT   = 20000;  // cycles with no transaction on either channel
    localparam int SETTLE_CYCLES = 400;
    localparam int RANDOM_ITEMS  = 80;
    localparam int RANDOM_PIECES = 8;

    // Fixed layout of the directed names
    localparam int NAME_A_AT    = 0;       // 01 'x' 00
    localparam int NAME_B_AT    = 3;       // 01 'y' -> A
    localparam int ZERO_PTR_AT  = 7;       // pointer onto the closing zero of A
    localparam int SELF_PTR_AT  = 9;       // pointer to itself
    localparam int LONG_LOOP_AT = 11;      // six copied bytes, then back to its own start
    localparam int STORE_TOP    = PACKET_BYTES - 1;

    // One result transaction as the block should deliver it
    typedef struct {
        logic [CHUNK_W-1:0] chunk;
        logic [CNT_W-1:0]   count;
        logic               last;
        logic               malformed;
        logic [CONS_W-1:0]  consumed;
    } name_piece_t;

    logic clk = 1'b0;
    logic rst_n;

    dnd_req_if req_ch ();
    dnd_res_if res_ch ();

    dns_name_decompressor DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Shadow of the packet store; only loaded entries may ever be walked over
    logic [BYTE_W-1:0] pkt_shadow [PACKET_BYTES];
    bit                pkt_loaded [PACKET_BYTES];

    name_piece_t walk_pieces[$];     // pieces of the walk just predicted
    name_piece_t awaited_pieces[$];  // pieces sent into the block, not yet seen at the output

    int unsigned items_sent    = 0;
    int unsigned pieces_queued = 0;
    int unsigned fail_count    = 0;
    int unsigned burst_left    = 0;
    int unsigned quiet_cycles  = 0;
    bit          sender_gaps_on = 1'b1;
    bit          hold_request   = 1'b0;

    // ------------------------------------------------------------------
    // Name walk predictor. Fills walk_pieces with the result transactions of
    // a resolve. If the walk would read a store entry that was never loaded,
    // it stops and returns that index so the caller can load it first;
    // otherwise it returns -1.
    // ------------------------------------------------------------------
    function automatic int walk_name(input int unsigned len_field, input int unsigned start);
        int unsigned len;
        int unsigned pos;
        int unsigned copied;
        int unsigned jumps;
        int unsigned consumed;
        int unsigned lane;
        int unsigned target;
        logic [CHUNK_W-1:0] chunk;
        logic [BYTE_W-1:0]  b;
        bit jumped;
        bit malformed;
        walk_pieces.delete();
        len       = (len_field > PACKET_BYTES) ? PACKET_BYTES : len_field;
        pos       = start;
        copied    = 0;
        jumps     = 0;
        consumed  = 0;
        lane      = 0;
        chunk     = '0;
        jumped    = 1'b0;
        malformed = 1'b0;
        if (pos >= len)
            malformed = 1'b1;   // start outside the packet
        else
        begin
            while (!malformed)
            begin
                if (!pkt_loaded[pos])
                    return pos;
                b = pkt_shadow[pos];
                if (b == NAME_END)
                    break;
                if (copied >= MAX_NAME_BYTES || jumps > MAX_JUMPS)
                    malformed = 1'b1;   // name too long / too many jumps
                else if ((b & PTR_MARK) == PTR_MARK)
                begin
                    if (pos + 1 >= len)
                        malformed = 1'b1;   // pointer cut off by the packet end
                    else if (!pkt_loaded[pos + 1])
                        return pos + 1;
                    else
                    begin
                        target = (int'(b & PTR_HI_MASK) << 8) | int'(pkt_shadow[pos + 1]);
                        if (target >= len)
                            malformed = 1'b1;   // pointer outside the packet
                        else if (!pkt_loaded[target])
                            return target;
                        else
                        begin
                            // only the first pointer counts toward the wire length
                            if (!jumped)
                            begin
                                consumed += 2;
                                jumped = 1'b1;
                            end
                            pos = target;
                            if (pkt_shadow[pos] == NAME_END)
                                malformed = 1'b1;   // pointer onto a zero byte
                            else
                                jumps++;
                        end
                    end
                end
                else
                begin
                    chunk[lane * BYTE_W +: BYTE_W] = b;
                    lane++;
                    if (lane == LANES)
                    begin
                        walk_pieces.push_back('{chunk, CNT_W'(LANES), 1'b0, 1'b0, '0});
                        chunk = '0;
                        lane  = 0;
                    end
                    if (!jumped)
                        consumed++;
                    pos++;
                    copied++;
                    if (pos >= len)
                        malformed = 1'b1;   // copied byte was the last of the packet
                end
            end
            if (!malformed && !jumped)
                consumed++;   // closing zero
        end
        walk_pieces.push_back('{chunk, CNT_W'(lane), 1'b1, malformed,
                                malformed ? '0 : CONS_W'(consumed)});
        return -1;
    endfunction

    // ------------------------------------------------------------------
    // Request side. The sender runs in bursts of random length separated by
    // random gaps (when sender_gaps_on). valid stays high across a burst so
    // back-to-back transactions never toggle it within one time step.
    // ------------------------------------------------------------------
    task automatic send_item(input req_kind_t kind, input logic [IDX_W-1:0] idx,
                             input logic [BYTE_W-1:0] val, input logic [LEN_W-1:0] len,
                             input logic [OFF_W-1:0] start);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = sender_gaps_on ? $urandom_range(0, 8) : 0;
            if (gap != 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_ch.valid         <= 1'b1;
        req_ch.req_type      <= kind;
        req_ch.byte_index    <= idx;
        req_ch.byte_value    <= val;
        req_ch.packet_length <= len;
        req_ch.start_offset  <= start;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        items_sent++;
    endtask

    task automatic load_byte(input int unsigned idx, input logic [BYTE_W-1:0] val);
        pkt_shadow[idx] = val;
        pkt_loaded[idx] = 1'b1;
        send_item(REQ_LOAD, IDX_W'(idx), val, LEN_W'($urandom), OFF_W'($urandom));
    endtask

    // Resolve a name. Any store entry the walk would touch without having been
    // loaded gets a random byte first (mostly name ends and short labels).
    task automatic resolve_name(input int unsigned len_field, input int unsigned start);
        int miss;
        int unsigned pick;
        miss = walk_name(len_field, start);
        while (miss >= 0)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                load_byte(miss, NAME_END);
            else if (pick < 85)
                load_byte(miss, BYTE_W'($urandom_range(1, 63)));
            else
                load_byte(miss, BYTE_W'($urandom));
            miss = walk_name(len_field, start);
        end
        foreach (walk_pieces[i])
            awaited_pieces.push_back(walk_pieces[i]);
        pieces_queued += walk_pieces.size();
        send_item(REQ_RESOLVE, IDX_W'($urandom), BYTE_W'($urandom), LEN_W'(len_field),
                  OFF_W'(start));
    endtask

    // Sender goes quiet until every awaited transaction has come out.
    // Always waits on the clock before its first check so valid never gets two updates in a step.
    task automatic wait_for_names();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (awaited_pieces.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Plain label, pointer into it, start outside the packet, copy off the end.
    task automatic test_plain_and_pointer_names();
        load_byte(NAME_A_AT,     8'h01);
        load_byte(NAME_A_AT + 1, "x");
        load_byte(NAME_A_AT + 2, NAME_END);
        load_byte(NAME_B_AT,     8'h01);
        load_byte(NAME_B_AT + 1, "y");
        load_byte(NAME_B_AT + 2, PTR_MARK);
        load_byte(NAME_B_AT + 3, BYTE_W'(NAME_A_AT));
        resolve_name(16, NAME_A_AT);
        resolve_name(16, NAME_B_AT);
        resolve_name(0, 0);              // empty packet
        resolve_name(2, NAME_A_AT);      // last copied byte is the packet's last byte
        wait_for_names();
    endtask

    // Malformed exits from pointers and walk limits, including the 255-byte limit and the pointer at the store top.
    task automatic test_malformed_names();
        load_byte(ZERO_PTR_AT,     PTR_MARK);
        load_byte(ZERO_PTR_AT + 1, BYTE_W'(NAME_A_AT + 2));
        load_byte(SELF_PTR_AT,     PTR_MARK);
        load_byte(SELF_PTR_AT + 1, BYTE_W'(SELF_PTR_AT));
        // six bytes per lap: hits the name limit after 42 jumps, before the jump limit
        load_byte(LONG_LOOP_AT, 8'h05);
        for (int k = 0; k < 5; k++)
            load_byte(LONG_LOOP_AT + 1 + k, BYTE_W'("p" + k));
        load_byte(LONG_LOOP_AT + 6, PTR_MARK);
        load_byte(LONG_LOOP_AT + 7, BYTE_W'(LONG_LOOP_AT));
        load_byte(STORE_TOP - 1, 8'hFF);
        load_byte(STORE_TOP,     8'hFF);
        resolve_name(16, ZERO_PTR_AT);
        resolve_name(16, SELF_PTR_AT);
        resolve_name(PACKET_BYTES, LONG_LOOP_AT);
        resolve_name(PACKET_BYTES, STORE_TOP);            // pointer's first byte is the last
        resolve_name(2 ** LEN_W - 1, STORE_TOP - 1);      // length clipped, target 0x3FFF out
        wait_for_names();
    endtask

    // Receiver holds off for a long stretch while resolves keep coming: the
    // result register, walker and command queue all fill and req.ready drops.
    task automatic test_result_backpressure();
        sender_gaps_on = 1'b0;
        hold_request   = 1'b1;
        for (int k = 0; k < 10; k++)
            resolve_name(PACKET_BYTES, (k % 2 == 0) ? LONG_LOOP_AT : NAME_B_AT);
        sender_gaps_on = 1'b1;
        wait_for_names();
    endtask

    // Mostly well-formed names (labels, then a zero, a pointer to an earlier
    // name or a loop back to itself) with random content, plus noise bytes,
    // unterminated names, tight packet lengths and random offsets.
    task automatic test_random_names();
        int unsigned first_item;
        int unsigned first_piece;
        int unsigned base;
        int unsigned pos;
        int unsigned lab_len;
        int unsigned target;
        int unsigned start;
        int unsigned len;
        int unsigned pick;
        int unsigned name_starts[$];
        first_item  = items_sent;
        first_piece = pieces_queued;
        name_starts = '{NAME_A_AT, NAME_B_AT, LONG_LOOP_AT};
        base = NAME_A_AT;
        pos  = NAME_A_AT + 2;
        while (items_sent - first_item < RANDOM_ITEMS ||
               pieces_queued - first_piece < RANDOM_PIECES)
        begin
            sender_gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) != 0)
            begin
                base = $urandom_range(0, PACKET_BYTES - 80);
                pos  = base;
                repeat ($urandom_range(1, 3))
                begin
                    lab_len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20)
                                                         : $urandom_range(1, 5);
                    load_byte(pos, BYTE_W'(lab_len));
                    pos++;
                    repeat (lab_len)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            load_byte(pos, BYTE_W'($urandom));     // noise byte
                        else
                            load_byte(pos, BYTE_W'($urandom_range(8'h21, 8'h7E)));
                        pos++;
                    end
                end
                pick = $urandom_range(0, 19);
                if (pick < 19)
                begin
                    if (pick < 10)
                        load_byte(pos, NAME_END);
                    else
                    begin
                        target = (pick < 17)
                                 ? name_starts[$urandom_range(0, name_starts.size() - 1)]
                                 : base;
                        load_byte(pos, PTR_MARK | BYTE_W'(target >> 8));
                        load_byte(pos + 1, BYTE_W'(target));
                    end
                end
                // pick == 19: left unterminated, the walk fills whatever it meets
                name_starts.push_back(base);
            end
            repeat ($urandom_range(1, 3))
            begin
                case ($urandom_range(0, 9))
                    0, 1:    start = $urandom_range(base, pos);
                    2:       start = $urandom_range(0, STORE_TOP);
                    default: start = name_starts[$urandom_range(0, name_starts.size() - 1)];
                endcase
                case ($urandom_range(0, 7))
                    0:       len = $urandom_range(PACKET_BYTES + 1, 2 ** LEN_W - 1);
                    1, 2:    len = start + $urandom_range(0, 24);
                    default: len = PACKET_BYTES;
                endcase
                resolve_name(len, start);
            end
        end
        sender_gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial
    begin
        req_ch.valid         = 1'b0;
        req_ch.req_type      = REQ_LOAD;
        req_ch.byte_index    = '0;
        req_ch.byte_value    = '0;
        req_ch.packet_length = '0;
        req_ch.start_offset  = '0;
        rst_n = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_plain_and_pointer_names();
        test_malformed_names();
        test_result_backpressure();
        test_random_names();

        // all stimulus in: wait for the tail, then give stray transactions a chance to show
        wait_for_names();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result receiver: ready follows an 8-bit rotating pattern that is redrawn
    // after each random-length phase (all-ready phases included); a hold request
    // from the backpressure test drops ready for a LONG_HOLD hold-off counted here.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned hold_left;
        int unsigned phase_left;
        logic [7:0]  pattern;
        hold_left    = 0;
        phase_left   = 0;
        pattern      = 8'hFF;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left    = LONG_HOLD;
                hold_request = 1'b0;
            end
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(16, 96);
                case ($urandom_range(0, 3))
                    0:       pattern = 8'hFF;
                    1:       pattern = 8'($urandom);
                    2:       pattern = 8'($urandom) | 8'($urandom);
                    default: pattern = 8'b0101_0101;
                endcase
            end
            phase_left--;
            if (hold_left != 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= pattern[0];
                pattern = {pattern[0], pattern[7:1]};
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: every accepted result transaction against the oldest awaited piece.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : check_results
        name_piece_t want;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (awaited_pieces.size() == 0)
            begin
                $error("unexpected result transaction: name_chunk %h chunk_bytes %0d is_last %0b",
                       res_ch.name_chunk, res_ch.chunk_bytes, res_ch.is_last);
                fail_count++;
            end
            else
            begin
                want = awaited_pieces.pop_front();
                if (res_ch.name_chunk !== want.chunk)
                begin
                    $error("name_chunk: expected %h, got %h", want.chunk, res_ch.name_chunk);
                    fail_count++;
                end
                if (res_ch.chunk_bytes !== want.count)
                begin
                    $error("chunk_bytes: expected %0d, got %0d", want.count, res_ch.chunk_bytes);
                    fail_count++;
                end
                if (res_ch.is_last !== want.last)
                begin
                    $error("is_last: expected %0b, got %0b", want.last, res_ch.is_last);
                    fail_count++;
                end
                if (res_ch.error_flag !== want.malformed)
                begin
                    $error("error_flag: expected %0b, got %0b", want.malformed,
                           res_ch.error_flag);
                    fail_count++;
                end
                if (res_ch.consumed_length !== want.consumed)
                begin
                    $error("consumed_length: expected %0d, got %0d", want.consumed,
                           res_ch.consumed_length);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too long without a transaction on either channel means a hang.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

endmodule

### sim.f
design/dnd_pkg.sv
design/dnd_if.sv
design/dnd_front.sv
design/dnd_queue.sv
design/dnd_back.sv
design/dns_name_decompressor.sv
bench/testbench.sv
